@@ hdl/ess_pkg.sv @@
// Package for the enveloped six-axis sine shake core: types and constants.
// No dependencies.
`default_nettype none
package ess_pkg;
    localparam int SINE_ANGLE_BITS = 16;
    localparam int QBITS           = SINE_ANGLE_BITS - 2;
    localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [2:0] REG_ROT_FREQ = 3'd0;
    localparam logic [2:0] REG_ROT_AMP  = 3'd1;
    localparam logic [2:0] REG_LOC_FREQ = 3'd2;
    localparam logic [2:0] REG_LOC_AMP  = 3'd3;
    localparam logic [2:0] REG_BLEND_IN = 3'd4;
    localparam logic [2:0] REG_BLEND_OUT = 3'd5;
    localparam logic [2:0] REG_DURATION = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] delta_time;
        logic [15:0] shake_scale;
        logic        immediate;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pitch_offset;
        logic signed [15:0] yaw_offset;
        logic signed [15:0] roll_offset;
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
        logic signed [15:0] z_offset;
        logic               finished;
    } t_out_item;

    // serial divider control
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
        logic [6:0]  nbits;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [31:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ hdl/ess_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ess_pkg.
`default_nettype none
module ess_div
    import ess_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [32:0] trial;

    always_comb begin
        n_rem = {r_rem[31:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        trial = n_rem - {1'b0, r_den};
        if (!trial[32]) begin
            n_rem = trial;
            n_q[0] = 1'b1;
        end
        n_cnt = r_cnt - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            // left-align numerator so only nbits iterations are needed
            r_q    <= i_req.num << (7'd64 - i_req.nbits);
            r_rem  <= '0;
            r_den  <= i_req.den;
            r_cnt  <= i_req.nbits;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= n_cnt;
            if (n_cnt == 7'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_rem[31:0];
endmodule
`default_nettype wire

@@ hdl/ess_mul.sv @@
// Serial shift-add multiplier, two multiplier bits per cycle.
// Depends on ess_pkg.
`default_nettype none
module ess_mul
    import ess_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [95:0]      o_p
);
    logic [95:0] r_acc, r_a;
    logic [31:0] r_b;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [95:0] pp;

    always_comb begin
        pp = (r_b[0] ? r_a : 96'd0) + (r_b[1] ? {r_a[94:0], 1'b0} : 96'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_acc  <= '0;
            r_a    <= {32'd0, i_a};
            r_b    <= i_b;
            r_cnt  <= 5'd15;
        end else if (r_busy) begin
            r_acc <= r_acc + pp;
            r_a   <= {r_a[93:0], 2'b00};
            r_b   <= {2'b00, r_b[31:2]};
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule
`default_nettype wire

@@ hdl/enveloped_six_axis_sine_shake_core.sv @@
// Top level of the enveloped six-axis sine shake core: sequencer over serial units.
// Depends on ess_pkg, ess_div, ess_mul.
// Sequence: a tick is accepted, its weight is found (with a ramp divide when the weight
// ramps) and multiplied by the scale, then per axis nine multiplies, two divides and one
// step follow; start, stop and ignored items leave the core idle and give no result.
// Flow: items are taken only while idle; a result held in the output register only
// delays the loading of the next tick's result and with it the taking of the next item.
// Reset (synchronous, active low): registers zero, elapsed time zero, inactive.
`default_nettype none
module enveloped_six_axis_sine_shake_core
    import ess_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_WDIV = 5'd1,  S_WWAIT = 5'd2,
                           S_WMUL = 5'd3,  S_WMW = 5'd4,   S_AMUL = 5'd5,
                           S_AMW = 5'd6,   S_MOD = 5'd7,   S_MODW = 5'd8,
                           S_IDX = 5'd9,   S_IDXW = 5'd10, S_U2 = 5'd11,
                           S_U2W = 5'd12,  S_HOR = 5'd13,  S_HORW = 5'd14,
                           S_LAST = 5'd15, S_LASTW = 5'd16, S_AMP = 5'd17,
                           S_AMPW = 5'd18, S_VW = 5'd19,   S_VWW = 5'd20,
                           S_NEXT = 5'd21, S_OUT = 5'd22;

    logic [47:0] r_rf, r_ra, r_lf, r_la;
    logic [31:0] r_bin, r_bout, r_dur, r_et;
    logic        r_act;
    logic [4:0]  r_st;
    logic [31:0] r_t;
    logic [16:0] r_w;
    logic [32:0] r_wt;
    logic [2:0]  r_ax;
    logic [2:0]  r_k;
    logic        r_fin;
    logic [15:0] r_scale;
    logic [63:0] r_tmp;
    logic [1:0]  r_quad;
    logic signed [33:0] r_u, r_u2, r_acc;
    logic        r_neg;
    logic [15:0] r_res [6];
    logic        r_ov;
    logic        r_out_v;
    t_out_item   r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic        mul_start, mul_done;
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic [95:0] mul_p;

    ess_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));
    ess_mul u_mul (.i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
                   .o_done(mul_done), .o_p(mul_p));

    logic [15:0] f_sel, a_sel;
    logic [1:0]  ph;
    logic [1:0]  lax;
    // location axes 3, 4, 5 map to fields 0, 1, 2
    assign lax = r_ax[1:0] + 2'd1;
    always_comb begin
        if (r_ax < 3'd3) begin
            f_sel = r_rf[16*r_ax[1:0] +: 16];
            a_sel = r_ra[16*r_ax[1:0] +: 16];
            ph    = 2'd0;
        end else begin
            f_sel = r_lf[16*lax +: 16];
            a_sel = r_la[16*lax +: 16];
            ph    = lax;
        end
    end

    logic [63:0] coef;
    always_comb begin
        case (r_k)
            3'd0: coef = 64'd1686629713;
            3'd1: coef = -64'sd693598668;
            3'd2: coef = 64'd85569304;
            3'd3: coef = -64'sd5026995;
            default: coef = 64'd172272;
        endcase
    end

    function automatic logic [33:0] mag(input logic signed [33:0] x);
        return x[33] ? -x : x;
    endfunction

    logic [32:0] tsum;
    logic signed [33:0] fade_start, nrem;
    assign tsum = {1'b0, r_et} + {17'd0, i_in_data.delta_time};
    assign fade_start = $signed({2'b0, r_dur}) - $signed({2'b0, r_bout});
    assign nrem = $signed({2'b0, r_dur}) - $signed({2'b0, r_t});

    logic accept;
    assign o_in_ready = (r_st == S_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = (r_st == S_IDLE);

    logic signed [33:0] hprod;
    assign hprod = (r_neg ? -$signed({1'b0, mul_p[62:30]}) : $signed({1'b0, mul_p[62:30]}));

    always_comb begin
        div_req = '0;
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        unique case (r_st)
            S_WDIV: begin
                div_req.start = 1'b1;
                div_req.nbits = 7'd48;
                div_req.den = (r_t < r_bin) ? r_bin : r_bout;
                div_req.num = (r_t < r_bin) ? {16'd0, r_t, 16'd0}
                                            : {14'd0, nrem, 16'd0};
            end
            S_WMUL: begin mul_start = 1'b1; mul_a = {47'd0, r_w}; mul_b = {16'd0, r_scale}; end
            S_AMUL: begin mul_start = 1'b1; mul_a = {32'd0, r_t}; mul_b = {16'd0, f_sel}; end
            S_MOD: begin
                div_req.start = 1'b1; div_req.nbits = 7'd64;
                div_req.num = r_tmp; div_req.den = {5'd0, TWO_PI_Q24};
            end
            S_IDX: begin
                div_req.start = 1'b1; div_req.nbits = 7'd64;
                div_req.num = r_tmp << SINE_ANGLE_BITS; div_req.den = {5'd0, TWO_PI_Q24};
            end
            S_U2: begin mul_start = 1'b1; mul_a = {30'd0, r_u}; mul_b = r_u[31:0]; end
            S_HOR: begin mul_start = 1'b1; mul_a = {30'd0, mag(r_acc)}; mul_b = r_u2[31:0]; end
            S_LAST: begin mul_start = 1'b1; mul_a = {30'd0, mag(r_acc)}; mul_b = r_u[31:0]; end
            S_AMP: begin mul_start = 1'b1; mul_a = {30'd0, mag(r_acc)}; mul_b = {16'd0, a_sel}; end
            S_VW: begin mul_start = 1'b1; mul_a = r_tmp; mul_b = r_wt[31:0]; end
            default: ;
        endcase
    end

    logic [63:0] idx;
    logic [QBITS:0] pos;
    assign idx = div_rsp.quo;
    always_comb begin
        pos = {1'b0, idx[QBITS-1:0]};
        if (idx[QBITS]) pos = {1'b1, {QBITS{1'b0}}} - pos;
    end

    logic [63:0] vsh;
    assign vsh = r_ov ? {32'd0, mul_p[95:64] + 32'd0} : mul_p[95:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf <= '0; r_ra <= '0; r_lf <= '0; r_la <= '0;
            r_bin <= '0; r_bout <= '0; r_dur <= '0;
            r_et <= '0; r_act <= 1'b0; r_st <= S_IDLE; r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_out_ready) r_out_v <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ROT_FREQ: r_rf <= i_cfg_data;
                    REG_ROT_AMP:  r_ra <= i_cfg_data;
                    REG_LOC_FREQ: r_lf <= i_cfg_data;
                    REG_LOC_AMP:  r_la <= i_cfg_data;
                    REG_BLEND_IN: r_bin <= i_cfg_data[31:0];
                    REG_BLEND_OUT: r_bout <= i_cfg_data[31:0];
                    REG_DURATION: r_dur <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (accept) begin
                    if (i_in_data.action == ACT_START) begin
                        r_et <= '0; r_act <= 1'b1;
                    end else if (i_in_data.action == ACT_STOP) begin
                        r_act <= 1'b0;
                        if (i_in_data.immediate) r_et <= r_dur;
                    end else if (i_in_data.action == ACT_TICK && r_act) begin
                        r_t <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
                        r_et <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
                        r_scale <= i_in_data.shake_scale;
                        r_st <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (r_t < r_bin) r_st <= S_WWAIT;
                    else if ($signed({2'b0, r_t}) > fade_start) begin
                        if (r_bout == '0 || nrem <= 0) begin
                            r_w <= '0; r_st <= S_WMUL;
                        end else r_st <= S_WWAIT;
                    end else begin
                        r_w <= 17'd65536; r_st <= S_WMUL;
                    end
                end
                S_WWAIT: if (div_rsp.done) begin
                    r_w <= (div_rsp.quo > 64'd65536) ? 17'd65536 : div_rsp.quo[16:0];
                    r_st <= S_WMUL;
                end
                S_WMUL: begin r_st <= S_WMW; r_ax <= '0; end
                S_WMW: if (mul_done) begin r_wt <= mul_p[32:0]; r_st <= S_AMUL; end
                S_AMUL: r_st <= S_AMW;
                S_AMW: if (mul_done) begin
                    r_tmp <= mul_p[63:0] + ({62'd0, ph} << 24);
                    r_st <= S_MOD;
                end
                S_MOD: r_st <= S_MODW;
                S_MODW: if (div_rsp.done) begin
                    r_tmp <= {32'd0, div_rsp.rem}; r_st <= S_IDX;
                end
                S_IDX: r_st <= S_IDXW;
                S_IDXW: if (div_rsp.done) begin
                    r_quad <= idx[QBITS+1:QBITS];
                    r_u <= 34'(pos) << (30 - QBITS);
                    r_st <= S_U2;
                end
                S_U2: r_st <= S_U2W;
                S_U2W: if (mul_done) begin
                    r_u2 <= $signed({1'b0, mul_p[62:30]});
                    r_acc <= 34'sd172272; r_k <= 3'd3; r_neg <= 1'b0;
                    r_st <= S_HOR;
                end
                S_HOR: begin r_neg <= r_acc[33]; r_st <= S_HORW; end
                S_HORW: if (mul_done) begin
                    r_acc <= hprod + $signed(coef[33:0]);
                    if (r_k == 3'd0) r_st <= S_LAST;
                    else begin r_k <= r_k - 3'd1; r_st <= S_HOR; end
                end
                S_LAST: begin r_neg <= r_acc[33]; r_st <= S_LASTW; end
                S_LASTW: if (mul_done) begin
                    if (hprod < 0) r_acc <= '0;
                    else if (hprod > 34'sd1073741824) r_acc <= 34'sd1073741824;
                    else r_acc <= hprod;
                    r_neg <= r_quad[1];
                    r_st <= S_AMP;
                end
                S_AMP: r_st <= S_AMPW;
                S_AMPW: if (mul_done) begin
                    r_tmp <= {22'd0, mul_p[63:22]}; r_st <= S_VW;
                    r_ov <= 1'b0;
                end
                S_VW: r_st <= S_VWW;
                S_VWW: if (mul_done) begin
                    // weight bit 32 only set when w*scale >= 2^32
                    logic [64:0] v;
                    v = {1'b0, vsh} + (r_wt[32] ? {1'b0, r_tmp} : 65'd0);
                    if (r_neg && r_acc != 0)
                        r_res[r_ax] <= (v >= 65'd32768) ? 16'h8000 : 16'(0 - v[15:0]);
                    else
                        r_res[r_ax] <= (v > 65'd32767) ? 16'h7FFF : v[15:0];
                    r_st <= S_NEXT;
                end
                S_NEXT: if (r_ax == 3'd5) begin
                    r_fin <= (r_t >= r_dur);
                    if (r_t >= r_dur) r_act <= 1'b0;
                    r_st <= S_OUT;
                end else begin
                    r_ax <= r_ax + 3'd1; r_st <= S_AMUL;
                end
                S_OUT: if (!r_out_v) begin
                    r_out.pitch_offset <= r_res[0];
                    r_out.yaw_offset   <= r_res[1];
                    r_out.roll_offset  <= r_res[2];
                    r_out.x_offset     <= r_res[3];
                    r_out.y_offset     <= r_res[4];
                    r_out.z_offset     <= r_res[5];
                    r_out.finished     <= r_fin;
                    r_out_v <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_st == S_IDLE) else $error("ready outside idle");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_st) == S_OUT) else $error("stray result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_in_ready) else $error("accept while busy");
endmodule
`default_nettype wire

@@ tb/enveloped_six_axis_sine_shake_core_tb.sv @@
// Testbench for enveloped_six_axis_sine_shake_core: directed and random start/tick/stop traffic,
// register settings and back-pressure, checked against a built-in predictor of the sine bank.
// Depends on ess_pkg and the core RTL.
`timescale 1ns / 1ps
module enveloped_six_axis_sine_shake_core_tb;
    import ess_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam longint      CYCLE_LIMIT  = 20_000_000;
    localparam int          DRAIN_CYCLES = 2000;
    localparam int          RANDOM_ITEMS = 1350;
    localparam longint      ONE_Q30      = 64'sd1073741824;
    localparam longint unsigned FULL_W   = 64'd65536;
    localparam longint unsigned TWO_PI   = 64'(TWO_PI_Q24);
    localparam logic [1:0]  ACT_NONE     = 2'd3;
    localparam longint      SINE_C [5]   = '{64'sd1686629713, -64'sd693598668, 64'sd85569304,
                                             -64'sd5026995, 64'sd172272};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    enveloped_six_axis_sine_shake_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [47:0] p_rot_freq, p_rot_amp, p_loc_freq, p_loc_amp;
    logic [31:0] p_blend_in, p_blend_out, p_duration;
    logic [31:0] p_elapsed;
    logic        p_active;

    t_out_item   offsets_due [$];
    int          errors = 0;
    int          n_items = 0, n_results = 0, n_cfg = 0, n_finished = 0, n_counted = 0;
    longint      cycles = 0;
    int          burst_left = 0;
    bit          no_gaps = 0;
    int          hold_req = 0;
    int          hold_cnt = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;

    function automatic longint q30_mul(longint a, longint b);
        bit neg;
        longint unsigned ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        p = (ma * mb) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint poly_sine(longint unsigned r);
        longint unsigned idx, quad, pos;
        longint u, u2, acc;
        idx = (r << SINE_ANGLE_BITS) / TWO_PI;
        quad = (idx >> QBITS) & 64'd3;
        pos = idx & ((64'd1 << QBITS) - 1);
        if (quad[0]) pos = (64'd1 << QBITS) - pos;
        u = longint'(pos << (30 - QBITS));
        u2 = q30_mul(u, u);
        acc = SINE_C[4];
        for (int k = 3; k >= 0; k--) acc = q30_mul(acc, u2) + SINE_C[k];
        acc = q30_mul(acc, u);
        if (acc < 0) acc = 0;
        if (acc > ONE_Q30) acc = ONE_Q30;
        return quad[1] ? -acc : acc;
    endfunction

    function automatic logic [15:0] axis_offset(logic [31:0] t, logic [47:0] freq_reg,
                                                logic [47:0] amp_reg, int axis,
                                                longint unsigned phase,
                                                longint unsigned weight);
        longint unsigned f, amp, a, ms, m, v;
        longint s;
        f = 64'(freq_reg[16*axis +: 16]);
        amp = 64'(amp_reg[16*axis +: 16]);
        a = 64'(t) * f + (phase << 24);
        s = poly_sine(a % TWO_PI);
        ms = (s < 0) ? longint'(-s) : s;
        m = (ms * amp) >> 22;
        v = (m * weight) >> 32;
        if (s < 0) return (v >= 64'd32768) ? 16'h8000 : 16'(64'd0 - v);
        return (v > 64'd32767) ? 16'h7FFF : 16'(v);
    endfunction

    // returns 1 when the item produces a result
    function automatic bit shake_predict(t_in_item it, output t_out_item res);
        longint unsigned sum, w, weight;
        longint fade_start, n;
        logic [31:0] t;
        res = '0;
        if (it.action == ACT_START) begin
            p_elapsed = '0;
            p_active = 1'b1;
            return 0;
        end
        if (it.action == ACT_STOP) begin
            p_active = 1'b0;
            if (it.immediate) p_elapsed = p_duration;
            return 0;
        end
        if (it.action != ACT_TICK || !p_active) return 0;
        sum = 64'(p_elapsed) + 64'(it.delta_time);
        t = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        p_elapsed = t;
        fade_start = longint'(64'(p_duration)) - longint'(64'(p_blend_out));
        if (t < p_blend_in) begin
            w = (64'(t) << 16) / 64'(p_blend_in);
        end else if (longint'(64'(t)) > fade_start) begin
            n = longint'(64'(p_duration)) - longint'(64'(t));
            if (p_blend_out == 0 || n <= 0) w = 0;
            else begin
                w = (longint'(n) << 16) / 64'(p_blend_out);
                if (w > FULL_W) w = FULL_W;
            end
        end else begin
            w = FULL_W;
        end
        weight = w * 64'(it.shake_scale);
        res.pitch_offset = axis_offset(t, p_rot_freq, p_rot_amp, 0, 0, weight);
        res.yaw_offset   = axis_offset(t, p_rot_freq, p_rot_amp, 1, 0, weight);
        res.roll_offset  = axis_offset(t, p_rot_freq, p_rot_amp, 2, 0, weight);
        res.x_offset     = axis_offset(t, p_loc_freq, p_loc_amp, 0, 0, weight);
        res.y_offset     = axis_offset(t, p_loc_freq, p_loc_amp, 1, 1, weight);
        res.z_offset     = axis_offset(t, p_loc_freq, p_loc_amp, 2, 2, weight);
        res.finished = 1'b0;
        if (t >= p_duration) begin
            p_active = 1'b0;
            res.finished = 1'b1;
        end
        return 1;
    endfunction

    // every task that drives starts and ends just after a falling edge
    task automatic send_item(logic [1:0] act, logic [15:0] dt, logic [15:0] scale, logic imm);
        t_in_item it;
        t_out_item res;
        int gap;
        it.action = act;
        it.delta_time = dt;
        it.shake_scale = scale;
        it.immediate = imm;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        n_counted++;
        if (shake_predict(it, res)) offsets_due.push_back(res);
        @(negedge i_clk);
        if (!no_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (offsets_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // block must be idle when this is called
    task automatic cfg_write(logic [2:0] idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_ROT_FREQ:  p_rot_freq = data;
            REG_ROT_AMP:   p_rot_amp = data;
            REG_LOC_FREQ:  p_loc_freq = data;
            REG_LOC_AMP:   p_loc_amp = data;
            REG_BLEND_IN:  p_blend_in = data[31:0];
            REG_BLEND_OUT: p_blend_out = data[31:0];
            REG_DURATION:  p_duration = data[31:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic cfg_all(logic [47:0] rf, logic [47:0] ra, logic [47:0] lf, logic [47:0] la,
                           logic [31:0] bi, logic [31:0] bo, logic [31:0] dur);
        cfg_write(REG_ROT_FREQ, rf);
        cfg_write(REG_ROT_AMP, ra);
        cfg_write(REG_LOC_FREQ, lf);
        cfg_write(REG_LOC_AMP, la);
        cfg_write(REG_BLEND_IN, {16'd0, bi});
        cfg_write(REG_BLEND_OUT, {16'd0, bo});
        cfg_write(REG_DURATION, {16'd0, dur});
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // registers at reset are all zero: a tick gives zero offsets and finishes at once
    task automatic test_reset_state();
        send_item(ACT_TICK, 16'h1234, 16'h0100, 1'b0);
        send_item(ACT_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_START, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'h0001, 16'hFFFF, 1'b0);
        send_item(ACT_TICK, 16'h0001, 16'hFFFF, 1'b0);
        wait_idle();
    endtask

    task automatic test_directed();
        cfg_all({3{16'hFFFF}}, {3{16'hFFFF}}, {16'h0003, 16'h0100, 16'hFFFF},
                {16'h4000, 16'h0080, 16'hFFFF}, 32'h0000_8000, 32'h0000_8000, 32'h0003_0000);
        send_item(ACT_START, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_TICK, 16'h0000, 16'h0100, 1'b0);
        send_item(ACT_TICK, 16'h4000, 16'hFFFF, 1'b1);
        send_item(ACT_TICK, 16'hFFFF, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'hFFFF, 16'h0100, 1'b0);
        send_item(ACT_TICK, 16'h8000, 16'h8000, 1'b0);
        send_item(ACT_TICK, 16'hFFFF, 16'h0100, 1'b0);
        send_item(ACT_TICK, 16'hFFFF, 16'h0100, 1'b0);
        send_item(ACT_TICK, 16'h0010, 16'h0100, 1'b0);   // after finish: ignored
        send_item(ACT_STOP, 16'h0000, 16'h0000, 1'b1);   // inactive stop still jumps time
        send_item(ACT_NONE, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_START, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'h1000, 16'h0200, 1'b0);
        send_item(ACT_STOP, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'h1000, 16'h0200, 1'b0);
        wait_idle();
        // no ramp-down length: weight drops to zero past the end
        cfg_all({3{16'h0321}}, {3{16'h7FFF}}, {3{16'h0200}}, {3{16'h1000}},
                32'd0, 32'd0, 32'h0001_0000);
        send_item(ACT_START, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'hFFFF, 16'h0100, 1'b0);
        send_item(ACT_TICK, 16'h0002, 16'h0100, 1'b0);
        wait_idle();
        // ramp-down longer than the duration and zero duration
        cfg_write(REG_BLEND_OUT, 48'h0000_FFFF_FFFF);
        send_item(ACT_START, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'h0100, 16'hFFFF, 1'b0);
        wait_idle();
        cfg_all('0, '0, '0, '0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(ACT_START, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TICK, 16'h0000, 16'hFFFF, 1'b0);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering; then the sender pauses for a drain
    task automatic test_backpressure();
        cfg_all(rand48(), rand48(), rand48(), rand48(), 32'h0000_4000, 32'h0000_4000,
                32'h00FF_0000);
        no_gaps = 1;
        send_item(ACT_START, 16'h0000, 16'h0000, 1'b0);
        hold_req = 6000;
        for (int k = 0; k < 8; k++) send_item(ACT_TICK, 16'($urandom), 16'($urandom), 1'b0);
        no_gaps = 0;
        i_in_valid <= 1'b0;
        while (offsets_due.size() != 0) @(negedge i_clk);
        for (int k = 0; k < 4; k++) send_item(ACT_TICK, 16'($urandom), 16'($urandom), 1'b0);
        wait_idle();
    endtask

    task automatic random_config();
        int sel;
        logic [31:0] dur, bi, bo;
        sel = $urandom_range(0, 5);
        dur = $urandom_range(0, 32'h0008_0000);
        bi = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h0004_0000);
        bo = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h0004_0000);
        if (sel == 0) cfg_all('0, '0, '0, '0, 32'd0, 32'd0, 32'd0);
        else if (sel == 1) cfg_all('1, '1, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        else if (sel == 2) cfg_all('1, '1, '1, '1, bi, bo, dur);
        else cfg_all(rand48(), rand48(), rand48(), rand48(), bi, bo,
                     ($urandom_range(0, 9) == 0) ? $urandom : dur);
    endtask

    task automatic test_random();
        int phase_start, len, r;
        logic [15:0] dt;
        phase_start = n_counted;
        random_config();
        while (n_counted < RANDOM_ITEMS) begin
            if (n_counted - phase_start >= 150) begin
                wait_idle();
                random_config();
                phase_start = n_counted;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // noise: stray codes, stops, ticks possibly while inactive
                send_item(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                send_item(ACT_START, 16'($urandom), 16'($urandom), 1'($urandom));
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++) begin
                    dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
                    send_item(ACT_TICK, dt, 16'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 2) == 0)
                    send_item(ACT_STOP, 16'($urandom), 16'($urandom), 1'($urandom));
            end
        end
        wait_idle();
    endtask

    // receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (stall_timer == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 400);
        end else begin
            stall_timer--;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 7) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && i_out_ready) begin
            if (offsets_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                want = offsets_due.pop_front();
                n_results++;
                if (want.finished) n_finished++;
                if (o_out_data.pitch_offset !== want.pitch_offset)
                    $display("%0t: pitch expected %h actual %h", $time,
                             want.pitch_offset, o_out_data.pitch_offset);
                if (o_out_data.yaw_offset !== want.yaw_offset)
                    $display("%0t: yaw expected %h actual %h", $time,
                             want.yaw_offset, o_out_data.yaw_offset);
                if (o_out_data.roll_offset !== want.roll_offset)
                    $display("%0t: roll expected %h actual %h", $time,
                             want.roll_offset, o_out_data.roll_offset);
                if (o_out_data.x_offset !== want.x_offset)
                    $display("%0t: x expected %h actual %h", $time,
                             want.x_offset, o_out_data.x_offset);
                if (o_out_data.y_offset !== want.y_offset)
                    $display("%0t: y expected %h actual %h", $time,
                             want.y_offset, o_out_data.y_offset);
                if (o_out_data.z_offset !== want.z_offset)
                    $display("%0t: z expected %h actual %h", $time,
                             want.z_offset, o_out_data.z_offset);
                if (o_out_data.finished !== want.finished)
                    $display("%0t: finished expected %b actual %b", $time,
                             want.finished, o_out_data.finished);
                if (o_out_data !== want) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, offsets_due.size());
            $display("** enveloped_six_axis_sine_shake_core: FAILED **");
            $finish;
        end
    end

    initial begin
        p_rot_freq = '0; p_rot_amp = '0; p_loc_freq = '0; p_loc_amp = '0;
        p_blend_in = '0; p_blend_out = '0; p_duration = '0;
        p_elapsed = '0; p_active = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_directed();
        test_backpressure();
        n_counted = 0;
        test_random();
        if (offsets_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, offsets_due.size());
            errors++;
        end
        $display("Sent %0d items (%0d in the random phase) over %0d register writes;",
                 n_items, n_counted, n_cfg);
        $display("checked %0d results, %0d of them ending a shake; %0d errors.",
                 n_results, n_finished, errors);
        if (errors == 0) begin
            $display("** enveloped_six_axis_sine_shake_core: PASSED **");
        end else begin
            $display("** enveloped_six_axis_sine_shake_core: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/ess_pkg.sv
hdl/ess_div.sv
hdl/ess_mul.sv
hdl/enveloped_six_axis_sine_shake_core.sv
tb/enveloped_six_axis_sine_shake_core_tb.sv
